// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the epoch-to-BCD calendar sequencer RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define E2B_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2B_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define E2B_ASSERT(lbl, clk, rst_n, prop, msg)
`define E2B_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/e2b_pkg.sv -----
// Package for the epoch-to-BCD calendar unit: constants, sequencer states,
// shared-unit operand/result types, month table and BCD helper. No dependencies.
package e2b_pkg;

    localparam int unsigned ACC_W = 31;

    localparam logic [ACC_W-1:0] SECS_PER_DAY  = 31'd86400;
    localparam logic [ACC_W-1:0] SECS_PER_HOUR = 31'd3600;
    localparam logic [ACC_W-1:0] SECS_PER_MIN  = 31'd60;
    localparam logic [ACC_W-1:0] DAYS_PER_WEEK = 31'd7;
    localparam logic [ACC_W-1:0] DAYS_LEAP     = 31'd366;
    localparam logic [ACC_W-1:0] DAYS_NORMAL   = 31'd365;
    localparam logic [ACC_W-1:0] CENTURY       = 31'd100;
    localparam logic [ACC_W-1:0] WDAY_OFFSET   = 31'd4;
    localparam logic [7:0]       FIRST_YEAR    = 8'd70;

    localparam logic [3:0] DAY_STEPS_TOP  = 4'd14;
    localparam logic [3:0] HOUR_STEPS_TOP = 4'd4;
    localparam logic [3:0] MIN_STEPS_TOP  = 4'd5;
    localparam logic [3:0] WDAY_STEPS_TOP = 4'd11;
    localparam logic [3:0] LAST_MONTH     = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOUR,
        ST_MIN,
        ST_WDAY,
        ST_YEAR,
        ST_MONTH,
        ST_MDAY,
        ST_YBASE,
        ST_YMOD,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } sub_op_t;

    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } sub_res_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] yy;
    } cal_t;

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // tens = v*103 >> 10, exact below 179
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 14'(v) * 14'd103;
        tens  = prod[13:10];
        units = v - 7'(7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

// ----- rtl/core/e2b_sub_unit.sv -----
// Shared compare/subtract unit of the epoch-to-BCD calendar sequencer.
// Depends on e2b_pkg.
module e2b_sub_unit
(
    input  e2b_pkg::sub_op_t  op,
    output e2b_pkg::sub_res_t res
);

    always_comb
    begin
        res.ge   = (op.a >= op.b);
        res.diff = op.a - op.b;
    end

endmodule

// ----- rtl/core/e2b_seq.sv -----
// Sequencer for the epoch-to-BCD calendar: restoring divisions, year
// whittling, month search and year reduction on one shared subtractor.
// Depends on e2b_pkg, e2b_sub_unit and assert_macros.svh.
`include "assert_macros.svh"

module e2b_seq
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [30:0]                epoch_seconds,
    input  logic [6:0]                 year_base,
    input  logic                       out_free,
    output logic                       busy,
    output logic                       done,
    output e2b_pkg::cal_t              cal
);

    e2b_pkg::seq_state_t state_reg, state_next;

    logic [30:0] acc_reg,    acc_next;
    logic [14:0] quo_reg,    quo_next;
    logic [3:0]  cnt_reg,    cnt_next;
    logic [14:0] days_reg,   days_next;
    logic [5:0]  second_reg, second_next;
    logic [5:0]  minute_reg, minute_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [2:0]  wday_reg,   wday_next;
    logic [7:0]  year_reg,   year_next;
    logic [3:0]  month_reg,  month_next;
    logic [4:0]  day_reg,    day_next;
    logic [6:0]  yy_reg,     yy_next;

    e2b_pkg::sub_op_t  op;
    e2b_pkg::sub_res_t res;

    logic        leap;
    logic [14:0] quo_shift;
    logic [30:0] acc_after;

    e2b_sub_unit u_sub
    (
        .op  (op),
        .res (res)
    );

    assign leap      = (year_reg[1:0] == 2'b00);
    assign quo_shift = {quo_reg[13:0], res.ge};
    assign acc_after = res.ge ? res.diff : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= e2b_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        days_reg   <= days_next;
        second_reg <= second_next;
        minute_reg <= minute_next;
        hour_reg   <= hour_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        yy_reg     <= yy_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        days_next   = days_reg;
        second_next = second_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        wday_next   = wday_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        yy_next     = yy_reg;
        op.a        = acc_reg;
        op.b        = '0;

        unique case (state_reg)
            e2b_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = epoch_seconds;
                    quo_next   = '0;
                    cnt_next   = e2b_pkg::DAY_STEPS_TOP;
                    state_next = e2b_pkg::ST_DAYS;
                end
            end
            e2b_pkg::ST_DAYS:
            begin
                op.b     = e2b_pkg::SECS_PER_DAY << cnt_reg;
                acc_next = acc_after;
                quo_next = quo_shift;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    days_next  = quo_shift;
                    cnt_next   = e2b_pkg::HOUR_STEPS_TOP;
                    state_next = e2b_pkg::ST_HOUR;
                end
            end
            e2b_pkg::ST_HOUR:
            begin
                op.b     = e2b_pkg::SECS_PER_HOUR << cnt_reg;
                acc_next = acc_after;
                quo_next = quo_shift;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    hour_next  = quo_shift[4:0];
                    cnt_next   = e2b_pkg::MIN_STEPS_TOP;
                    state_next = e2b_pkg::ST_MIN;
                end
            end
            e2b_pkg::ST_MIN:
            begin
                op.b     = e2b_pkg::SECS_PER_MIN << cnt_reg;
                acc_next = acc_after;
                quo_next = quo_shift;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    minute_next = quo_shift[5:0];
                    second_next = acc_after[5:0];
                    acc_next    = 31'(days_reg) + e2b_pkg::WDAY_OFFSET;
                    cnt_next    = e2b_pkg::WDAY_STEPS_TOP;
                    state_next  = e2b_pkg::ST_WDAY;
                end
            end
            e2b_pkg::ST_WDAY:
            begin
                op.b     = e2b_pkg::DAYS_PER_WEEK << cnt_reg;
                acc_next = acc_after;
                quo_next = quo_shift;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    wday_next  = acc_after[2:0] + 3'd1;
                    acc_next   = 31'(days_reg);
                    year_next  = e2b_pkg::FIRST_YEAR;
                    state_next = e2b_pkg::ST_YEAR;
                end
            end
            e2b_pkg::ST_YEAR:
            begin
                op.b = leap ? e2b_pkg::DAYS_LEAP : e2b_pkg::DAYS_NORMAL;
                if (res.ge)
                begin
                    acc_next  = res.diff;
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    month_next = 4'd1;
                    state_next = e2b_pkg::ST_MONTH;
                end
            end
            e2b_pkg::ST_MONTH:
            begin
                op.b = 31'(e2b_pkg::month_start(month_reg))
                     + 31'(leap && (month_reg > 4'd1));
                if ((month_reg == e2b_pkg::LAST_MONTH) || !res.ge)
                begin
                    state_next = e2b_pkg::ST_MDAY;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
            e2b_pkg::ST_MDAY:
            begin
                op.b = 31'(e2b_pkg::month_start(month_reg - 4'd1))
                     + 31'(leap && (month_reg > 4'd2));
                day_next   = res.diff[4:0] + 5'd1;
                state_next = e2b_pkg::ST_YBASE;
            end
            e2b_pkg::ST_YBASE:
            begin
                // bias by a century so the difference never goes negative
                op.a       = 31'(year_reg) + e2b_pkg::CENTURY;
                op.b       = 31'(year_base);
                acc_next   = res.diff;
                state_next = e2b_pkg::ST_YMOD;
            end
            e2b_pkg::ST_YMOD:
            begin
                op.b = e2b_pkg::CENTURY;
                if (res.ge)
                begin
                    acc_next = res.diff;
                end
                else
                begin
                    yy_next    = acc_reg[6:0];
                    state_next = e2b_pkg::ST_DONE;
                end
            end
            e2b_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = e2b_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = e2b_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != e2b_pkg::ST_IDLE);
    assign done = (state_reg == e2b_pkg::ST_DONE);

    assign cal.second = second_reg;
    assign cal.minute = minute_reg;
    assign cal.hour   = hour_reg;
    assign cal.wday   = wday_reg;
    assign cal.day    = day_reg;
    assign cal.month  = month_reg;
    assign cal.yy     = yy_reg;

    `E2B_ASSERT(a_start, clk, rst_n, (!busy && in_valid) |=> (state_reg == e2b_pkg::ST_DAYS), "word not started")
    `E2B_ASSERT_IMPL(a_doy, clk, rst_n, state_reg == e2b_pkg::ST_MONTH, (acc_reg < e2b_pkg::DAYS_LEAP) && (year_reg >= e2b_pkg::FIRST_YEAR) && (year_reg <= 8'd138), "day of year or year out of range")
    `E2B_ASSERT_IMPL(a_month, clk, rst_n, state_reg == e2b_pkg::ST_MDAY, (month_reg >= 4'd1) && (month_reg <= e2b_pkg::LAST_MONTH), "month out of range")
    `E2B_ASSERT_IMPL(a_ymod, clk, rst_n, state_reg == e2b_pkg::ST_YMOD, acc_reg < 31'd239, "year reduction out of range")

endmodule

// ----- rtl/core/epoch_seconds_to_bcd_datetime_unit.sv -----
// Top level of the epoch-to-BCD calendar unit: year_base register, sequencer
// and output word register. Depends on e2b_pkg, e2b_seq and e2b_sub_unit.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------
//   cfg      | in        | cfg_we                 | cfg_wdata (year_base)
//   in       | in        | in_valid / in_stall    | epoch_seconds
//   out      | out       | out_valid / out_stall  | bcd_second .. bcd_year
//
// A word runs the restoring divisions, then the year loop on the shared subtractor, which
// removes one year's days per pass and can set most of the time from acceptance to out_valid.
// in_stall is high from acceptance until the result moves to the output register.
// A finished word waits in the sequencer while the output register is stalled.
// rst_n clears control and sets year_base to 0; no clearing pass.
module epoch_seconds_to_bcd_datetime_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [30:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  bcd_second,
    output logic [6:0]  bcd_minute,
    output logic [5:0]  bcd_hour,
    output logic [2:0]  bcd_weekday,
    output logic [5:0]  bcd_day,
    output logic [4:0]  bcd_month,
    output logic [7:0]  bcd_year
);

    logic [6:0]    year_base_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_free;
    logic          busy;
    logic          done;
    logic          load;
    e2b_pkg::cal_t cal;

    logic [6:0] bcd_second_reg;
    logic [6:0] bcd_minute_reg;
    logic [5:0] bcd_hour_reg;
    logic [2:0] bcd_weekday_reg;
    logic [5:0] bcd_day_reg;
    logic [4:0] bcd_month_reg;
    logic [7:0] bcd_year_reg;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [7:0] month_bcd;

    e2b_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .epoch_seconds (epoch_seconds),
        .year_base     (year_base_reg),
        .out_free      (out_free),
        .busy          (busy),
        .done          (done),
        .cal           (cal)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = done && out_free;
    assign in_stall = busy;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                year_base_reg <= cfg_wdata;
            end
        end
    end

    assign sec_bcd   = e2b_pkg::to_bcd(7'(cal.second));
    assign min_bcd   = e2b_pkg::to_bcd(7'(cal.minute));
    assign hour_bcd  = e2b_pkg::to_bcd(7'(cal.hour));
    assign day_bcd   = e2b_pkg::to_bcd(7'(cal.day));
    assign month_bcd = e2b_pkg::to_bcd(7'(cal.month));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_second_reg  <= sec_bcd[6:0];
            bcd_minute_reg  <= min_bcd[6:0];
            bcd_hour_reg    <= hour_bcd[5:0];
            bcd_weekday_reg <= cal.wday;
            bcd_day_reg     <= day_bcd[5:0];
            bcd_month_reg   <= month_bcd[4:0];
            bcd_year_reg    <= e2b_pkg::to_bcd(cal.yy);
        end
    end

    assign out_valid   = out_valid_reg;
    assign bcd_second  = bcd_second_reg;
    assign bcd_minute  = bcd_minute_reg;
    assign bcd_hour    = bcd_hour_reg;
    assign bcd_weekday = bcd_weekday_reg;
    assign bcd_day     = bcd_day_reg;
    assign bcd_month   = bcd_month_reg;
    assign bcd_year    = bcd_year_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for epoch_seconds_to_bcd_datetime_unit: a directed table, then random
// phases at several year_base and idle settings, untyped words checked on a calendar model.
// Depends on the RTL top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_CYCLES = 4000;
    localparam int          DRAIN_CYCLES    = 150;
    localparam int          PHASE_COUNT     = 8;
    localparam int          PHASE_WORDS     = 79;
    localparam int          DIRECTED_ROWS   = 22;
    localparam int unsigned LAST_DAY        = 24855;
    localparam longint      MAX_EPOCH       = 64'h7fff_ffff;

    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [2:0] weekday;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
    } rtc_word_t;

    typedef struct packed {
        logic [30:0] secs;
        logic        typed;
        rtc_word_t   want;
    } epoch_row_t;

    // typed rows hold base-0 results straight after reset
    localparam epoch_row_t EPOCH_ROWS [DIRECTED_ROWS] = '{
        '{31'd0,          1'b1, '{7'h00, 7'h00, 6'h00, 3'd5, 6'h01, 5'h01, 8'h70}},
        '{31'd45296,      1'b1, '{7'h56, 7'h34, 6'h12, 3'd5, 6'h01, 5'h01, 8'h70}},
        '{31'd86399,      1'b1, '{7'h59, 7'h59, 6'h23, 3'd5, 6'h01, 5'h01, 8'h70}},
        '{31'd86400,      1'b1, '{7'h00, 7'h00, 6'h00, 3'd6, 6'h02, 5'h01, 8'h70}},
        '{31'd172800,     1'b1, '{7'h00, 7'h00, 6'h00, 3'd7, 6'h03, 5'h01, 8'h70}},
        '{31'd259200,     1'b1, '{7'h00, 7'h00, 6'h00, 3'd1, 6'h04, 5'h01, 8'h70}},
        '{31'd2147483647, 1'b1, '{7'h07, 7'h14, 6'h03, 3'd3, 6'h19, 5'h01, 8'h38}},
        '{31'd946684799,  1'b1, '{7'h59, 7'h59, 6'h23, 3'd6, 6'h31, 5'h12, 8'h99}},
        '{31'd946684800,  1'b1, '{7'h00, 7'h00, 6'h00, 3'd7, 6'h01, 5'h01, 8'h00}},
        '{31'd31449600,   1'b0, '0},
        '{31'd31535999,   1'b0, '0},
        '{31'd31536000,   1'b0, '0},
        '{31'd68169600,   1'b0, '0},
        '{31'd68255999,   1'b0, '0},
        '{31'd68256000,   1'b0, '0},
        '{31'd94694399,   1'b0, '0},
        '{31'd94694400,   1'b0, '0},
        '{31'd951782400,  1'b0, '0},
        '{31'd978307199,  1'b0, '0},
        '{31'd1073741824, 1'b0, '0},
        '{31'd1431655765, 1'b0, '0},
        '{31'd2147472000, 1'b0, '0}
    };

    // negative base means a random one
    localparam int PHASE_BASE [PHASE_COUNT] = '{127, 69, 70, 0, -1, 100, 1, -1};
    localparam idle_mode_t PHASE_MODE [PHASE_COUNT] = '{IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER, IDLE_NONE};

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [6:0]  cfg_wdata     = '0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [30:0] epoch_seconds = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [6:0]  bcd_second;
    logic [6:0]  bcd_minute;
    logic [5:0]  bcd_hour;
    logic [2:0]  bcd_weekday;
    logic [5:0]  bcd_day;
    logic [4:0]  bcd_month;
    logic [7:0]  bcd_year;

    rtc_word_t   calendar_due [$];
    logic [6:0]  year_base_copy = '0;
    idle_mode_t  idle_mode      = IDLE_NONE;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;

    epoch_seconds_to_bcd_datetime_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .epoch_seconds (epoch_seconds),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bcd_second    (bcd_second),
        .bcd_minute    (bcd_minute),
        .bcd_hour      (bcd_hour),
        .bcd_weekday   (bcd_weekday),
        .bcd_day       (bcd_day),
        .bcd_month     (bcd_month),
        .bcd_year      (bcd_year)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] packed_bcd(int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic bit is_leap_year(int unsigned yr);
        return (yr % 4) == 0;
    endfunction

    function automatic rtc_word_t calendar_of(logic [30:0] secs, logic [6:0] base);
        rtc_word_t   w;
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned mon;
        int unsigned mday;
        int unsigned yy;
        bit          leap;
        days = secs / 86400;
        rem  = secs % 86400;
        w.weekday = 3'((days + 4) % 7 + 1);
        yr = 70;
        while (days >= (is_leap_year(yr) ? 366 : 365))
        begin
            days -= is_leap_year(yr) ? 366 : 365;
            yr++;
        end
        leap = is_leap_year(yr);
        mon  = 1;
        while (mon < 12 && days >= MONTH_START[mon] + ((leap && mon > 1) ? 1 : 0))
            mon++;
        mday = days - MONTH_START[mon - 1] + 1;
        if (leap && mon > 2)
            mday--;
        if (yr >= base)
            yy = (yr - base) % 100;
        else
            yy = (100 - ((base - yr) % 100)) % 100;
        w.second = 7'(packed_bcd(rem % 60));
        w.minute = 7'(packed_bcd((rem % 3600) / 60));
        w.hour   = 6'(packed_bcd(rem / 3600));
        w.day    = 6'(packed_bcd(mday));
        w.month  = 5'(packed_bcd(mon));
        w.year   = packed_bcd(yy);
        return w;
    endfunction

    // mix of raw counts, day edges and month/year edges
    function automatic logic [30:0] pick_epoch();
        longint      secs;
        int unsigned days;
        int unsigned span;
        int unsigned m;
        case ($urandom_range(0, 2))
            0: secs = longint'($urandom & 32'h7fff_ffff);
            1:
            begin
                days = $urandom_range(0, LAST_DAY);
                case ($urandom_range(0, 2))
                    0:       secs = longint'(days) * 86400;
                    1:       secs = longint'(days) * 86400 + 86399;
                    default: secs = longint'(days) * 86400 + $urandom_range(0, 86399);
                endcase
            end
            default:
            begin
                span = $urandom_range(0, 67);
                days = 0;
                for (int unsigned y = 70; y < 70 + span; y++)
                    days += is_leap_year(y) ? 366 : 365;
                m = $urandom_range(0, 11);
                days += MONTH_START[m] + ((is_leap_year(70 + span) && m >= 2) ? 1 : 0);
                secs = longint'(days) * 86400 - $urandom_range(0, 1);
            end
        endcase
        if (secs < 0)
            secs = 0;
        if (secs > MAX_EPOCH)
            secs = MAX_EPOCH;
        return 31'(secs);
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_epoch(logic [30:0] secs, bit typed, rtc_word_t want);
        while (roll(idle_mode == IDLE_SENDER ? 75 : (idle_mode == IDLE_BOTH ? 6 : 0)))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        calendar_due.push_back(typed ? want : calendar_of(secs, year_base_copy));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        rtc_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (calendar_due.size() == 0)
                begin
                    $display("%0t: unexpected word, year %h month %h day %h", $time,
                             bcd_year, bcd_month, bcd_day);
                    mismatches++;
                end
                else
                begin
                    want = calendar_due.pop_front();
                    check_field("bcd_second",  want.second,  bcd_second);
                    check_field("bcd_minute",  want.minute,  bcd_minute);
                    check_field("bcd_hour",    want.hour,    bcd_hour);
                    check_field("bcd_weekday", want.weekday, bcd_weekday);
                    check_field("bcd_day",     want.day,     bcd_day);
                    check_field("bcd_month",   want.month,   bcd_month);
                    check_field("bcd_year",    want.year,    bcd_year);
                end
            end
            out_stall <= roll(idle_mode == IDLE_RECEIVER ? 75 :
                              (idle_mode == IDLE_BOTH ? 6 : 0));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] base;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_epoch(EPOCH_ROWS[i].secs, EPOCH_ROWS[i].typed, EPOCH_ROWS[i].want);
        in_valid <= 1'b0;

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            while (calendar_due.size() != 0)
                @(posedge clk);
            base = PHASE_BASE[p] < 0 ? 7'($urandom_range(0, 127)) : 7'(PHASE_BASE[p]);
            cfg_we    <= 1'b1;
            cfg_wdata <= base;
            @(posedge clk);
            cfg_we         <= 1'b0;
            year_base_copy  = base;
            idle_mode       = PHASE_MODE[p];
            for (int n = 0; n < PHASE_WORDS; n++)
                send_epoch(pick_epoch(), 1'b0, '0);
            in_valid <= 1'b0;
        end

        while (calendar_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
